### rtl/page_frame_buffer_manager_unit_macros.svh
// Assertion macros shared by the page frame buffer manager RTL.
// Included by modules that carry concurrent checks.
`ifndef PAGE_FRAME_BUFFER_MANAGER_UNIT_MACROS_SVH
`define PAGE_FRAME_BUFFER_MANAGER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PFBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A stalled beat keeps valid high and its payload unchanged.
`define PFBM_ASSERT_HOLD(label, clk, rst_n, vld, stl, data, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(data))) else $error(msg);
`endif

### rtl/pfbm_pkg.sv
// Package for the page frame buffer manager: beat types, codes, constants.
// No dependencies.
package pfbm_pkg;
    localparam int NUM_FRAMES_DEF = 32;
    localparam int MAX_RESULTS    = 32;

    localparam logic [2:0] CMD_GET    = 3'd0;
    localparam logic [2:0] CMD_ALLOC  = 3'd1;
    localparam logic [2:0] CMD_UNPIN  = 3'd2;
    localparam logic [2:0] CMD_DIRTY  = 3'd3;
    localparam logic [2:0] CMD_FORCE  = 3'd4;
    localparam logic [2:0] CMD_FLUSH  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  file_id;
        logic [23:0] page_number;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  frame_index;
        logic        need_read;
        logic        writeback_valid;
        logic [9:0]  writeback_file;
        logic [23:0] writeback_page;
        logic        last;
    } t_out_beat;
endpackage

### rtl/pfbm_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module pfbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/page_frame_buffer_manager_unit.sv
// Page frame buffer manager: one sequencer steps over the frames (tag scan
// one per cycle) through a shared tag RAM read port and a single key comparator.
// Depends on pfbm_pkg, pfbm_ram and the assertion macro header.
//
// Usage:
//  - Input channel i_in_valid / o_in_stall carries one command beat
//    (t_in_beat). Stalled while a command or its result beat is in flight.
//  - Output channel o_out_valid / i_out_stall carries result beats
//    (t_out_beat); the final beat of a command has last set.
//  - Config channel i_cfg_valid / o_cfg_ready writes frames_in_use; the
//    value is clamped to 1..NUM_FRAMES and the pool is reinitialized.
//  - Sequencing: a lookup scans all NUM_FRAMES tags, one per cycle; eviction
//    walks the used chain from its tail, one frame per cycle; flush walks it
//    from the head, reading and then checking each frame. A new command is
//    taken only after the previous one's result beats have been accepted.
//  - Reset: empty pool, free chain 0..frames_in_use-1, frames_in_use =
//    min(32, NUM_FRAMES). Tags need no clearing (valid bits gate them).
//  - A stalled result beat holds; the sequencer waits on it.
`include "page_frame_buffer_manager_unit_macros.svh"
module page_frame_buffer_manager_unit #(
    parameter int NUM_FRAMES = pfbm_pkg::NUM_FRAMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pfbm_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pfbm_pkg::t_out_beat o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data
);
    import pfbm_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int LW = FW + 1;                   // link width, MSB = null
    localparam logic [LW-1:0] NIL = {1'b1, {FW{1'b0}}};
    localparam int RST_FIU = (32 < NUM_FRAMES) ? 32 : NUM_FRAMES;
    localparam int TW = 34;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_EVRD   = 9'b000001000,
        S_EVCHK  = 9'b000010000,
        S_FLRD   = 9'b000100000,
        S_FLCHK  = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_INIT   = 9'b100000000
    } t_state;

    t_state           r_state;
    t_in_beat         r_cmd;
    logic [5:0]       r_fiu;
    logic [NUM_FRAMES-1:0] r_valid, r_dirty;
    logic [7:0]       r_pins [NUM_FRAMES];
    logic [LW-1:0]    r_next [NUM_FRAMES];
    logic [LW-1:0]    r_prev [NUM_FRAMES];
    logic [LW-1:0]    r_free_head, r_used_head, r_used_tail;
    logic [FW:0]      r_cnt;          // scan address / walk step count
    logic [FW-1:0]    r_addr;         // address presented to the tag RAM
    logic             r_rd;           // a read was issued last cycle
    logic             r_hit;
    logic [FW-1:0]    r_hit_idx;
    logic [LW-1:0]    r_walk;
    logic             r_flush_any;
    logic [5:0]       r_nres;
    t_out_beat        r_out;
    t_out_beat        r_pend;         // flush beat waiting for the next match
    logic             r_out_valid;

    logic             r_tag_we;
    logic [FW-1:0]    r_tag_waddr;
    logic [TW-1:0]    tag_rdata;
    logic [FW-1:0]    rd_idx;
    logic             key_eq;
    logic [FW-1:0]    w_idx;
    t_out_beat        pend_last;

    pfbm_ram #(.WIDTH(TW), .DEPTH(NUM_FRAMES)) u_tags (
        .i_clk  (i_clk),
        .i_we   (r_tag_we),
        .i_waddr(r_tag_waddr),
        .i_wdata({r_cmd.file_id, r_cmd.page_number}),
        .i_raddr(rd_idx),
        .o_rdata(tag_rdata)
    );

    // the one shared comparator
    assign key_eq = (tag_rdata[33:24] == r_cmd.file_id)
        && (r_cmd.cmd == CMD_FLUSH || tag_rdata[23:0] == r_cmd.page_number);

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_idx       = r_walk[FW-1:0];

    // scan presents its counter, flush presents the walk pointer so the tag
    // is ready in the compare cycle
    always_comb begin
        rd_idx = r_addr;
        if (r_state == S_SCAN) begin
            rd_idx = r_cnt[FW-1:0];
        end else if (r_state == S_FLRD) begin
            rd_idx = w_idx;
        end
    end

    t_out_beat mk;
    always_comb begin
        mk = '0;
        mk.last = 1'b1;
    end

    always_comb begin
        pend_last = r_pend;
        pend_last.last = 1'b1;
    end

    logic [5:0] cfg_clamp;
    always_comb begin
        cfg_clamp = i_cfg_data;
        if (cfg_clamp == 6'd0) begin
            cfg_clamp = 6'd1;
        end
        if ({1'b0, cfg_clamp} > 7'(NUM_FRAMES)) begin
            cfg_clamp = 6'(NUM_FRAMES);
        end
    end

    // Main sequencer: all state is written here.
    always_ff @(posedge i_clk) begin
        r_tag_we <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_fiu       <= 6'(RST_FIU);
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    for (int i = 0; i < NUM_FRAMES; i++) begin
                        r_pins[i] <= '0;
                        r_next[i] <= (i + 1 < int'(r_fiu)) ? LW'(i + 1) : NIL;
                        r_prev[i] <= (i > 0 && i < int'(r_fiu)) ? LW'(i - 1) : NIL;
                    end
                    r_valid     <= '0;
                    r_dirty     <= '0;
                    r_free_head <= '0;
                    r_used_head <= NIL;
                    r_used_tail <= NIL;
                    r_state     <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_fiu   <= cfg_clamp;
                        r_state <= S_INIT;
                    end else if (i_in_valid && !o_in_stall) begin
                        r_cmd       <= i_in;
                        r_cnt       <= '0;
                        r_rd        <= 1'b0;
                        r_hit       <= 1'b0;
                        r_nres      <= '0;
                        r_flush_any <= 1'b0;
                        r_walk      <= r_used_head;
                        if (i_in.cmd > CMD_FLUSH) begin
                            r_out   <= mk;
                            r_state <= S_OUT;
                        end else if (i_in.cmd == CMD_FLUSH) begin
                            r_state <= S_FLRD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // read frame r_cnt, compare frame read last cycle
                    r_addr <= r_cnt[FW-1:0];
                    r_rd   <= (r_cnt < (FW+1)'(NUM_FRAMES));
                    if (r_rd && !r_hit && key_eq && r_valid[r_addr]) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_addr;
                    end
                    if (r_cnt == (FW+1)'(NUM_FRAMES)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_out <= mk;
                    r_state <= S_OUT;
                    if (r_cmd.cmd == CMD_GET || r_cmd.cmd == CMD_ALLOC) begin
                        if (r_hit) begin
                            r_out.frame_index <= 5'(r_hit_idx);
                            if (r_cmd.cmd == CMD_ALLOC) begin
                                r_out.status <= ST_PRESENT;
                            end else if (r_pins[r_hit_idx] != 8'hFF) begin
                                r_pins[r_hit_idx] <= r_pins[r_hit_idx] + 1'b1;
                            end
                        end else if (!r_free_head[FW]) begin
                            // take free head and push on used head
                            r_free_head <= r_next[r_free_head[FW-1:0]];
                            if (!r_next[r_free_head[FW-1:0]][FW]) begin
                                r_prev[r_next[r_free_head[FW-1:0]][FW-1:0]] <= NIL;
                            end
                            r_walk <= r_free_head;
                            r_cnt  <= '0;
                            r_state <= S_EVCHK;
                            r_hit  <= 1'b1;  // marks "frame chosen, not evicted"
                        end else begin
                            r_walk <= r_used_tail;
                            r_cnt  <= '0;
                            r_hit  <= 1'b0;
                            r_state <= S_EVRD;
                        end
                    end else if (!r_hit) begin
                        r_out.status <= ST_ABSENT;
                    end else begin
                        r_out.frame_index <= 5'(r_hit_idx);
                        case (r_cmd.cmd)
                            CMD_UNPIN: begin
                                if (r_pins[r_hit_idx] != 8'd0) begin
                                    r_pins[r_hit_idx] <= r_pins[r_hit_idx] - 1'b1;
                                end
                            end
                            CMD_DIRTY: r_dirty[r_hit_idx] <= 1'b1;
                            default: begin
                                if (r_dirty[r_hit_idx]) begin
                                    r_dirty[r_hit_idx]     <= 1'b0;
                                    r_out.writeback_valid  <= 1'b1;
                                    r_out.writeback_file   <= r_cmd.file_id;
                                    r_out.writeback_page   <= r_cmd.page_number;
                                end
                            end
                        endcase
                    end
                end
                S_EVRD: begin
                    // walk used chain from tail for an unpinned frame
                    if (r_walk[FW] || r_cnt == (FW+1)'(NUM_FRAMES)) begin
                        r_out.status <= ST_NOFREE;
                        r_state <= S_OUT;
                    end else if (r_pins[w_idx] == 8'd0) begin
                        r_addr  <= w_idx;
                        r_cnt   <= '0;
                        r_state <= S_EVCHK;
                        // unlink from used chain
                        if (!r_prev[w_idx][FW]) begin
                            r_next[r_prev[w_idx][FW-1:0]] <= r_next[w_idx];
                        end else begin
                            r_used_head <= r_next[w_idx];
                        end
                        if (!r_next[w_idx][FW]) begin
                            r_prev[r_next[w_idx][FW-1:0]] <= r_prev[w_idx];
                        end else begin
                            r_used_tail <= r_prev[w_idx];
                        end
                    end else begin
                        r_walk <= r_prev[w_idx];
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_EVCHK: begin
                    // victim tag read issued on entry, its data used once r_cnt[0] is set (ignored if free frame)
                    if (r_cnt[0] == 1'b0 && !r_hit) begin
                        r_cnt[0] <= 1'b1;  // wait for the victim tag data
                    end else begin
                        if (!r_hit && r_dirty[w_idx]) begin
                            r_out.writeback_valid <= 1'b1;
                            r_out.writeback_file  <= tag_rdata[33:24];
                            r_out.writeback_page  <= tag_rdata[23:0];
                        end
                        // push on used head (unlink or free-chain pop already done in an earlier state)
                        r_prev[w_idx] <= NIL;
                        r_next[w_idx] <= r_used_head;
                        if (!r_used_head[FW]) begin
                            r_prev[r_used_head[FW-1:0]] <= r_walk;
                        end else begin
                            r_used_tail <= r_walk;
                        end
                        r_used_head <= r_walk;
                        r_tag_we    <= 1'b1;
                        r_tag_waddr <= w_idx;
                        r_dirty[w_idx] <= 1'b0;
                        r_valid[w_idx] <= 1'b1;
                        r_pins[w_idx]  <= 8'd1;
                        r_out.frame_index <= 5'(w_idx);
                        r_out.need_read   <= (r_cmd.cmd == CMD_GET);
                        r_state <= S_OUT;
                    end
                end
                S_FLRD: begin
                    if (r_walk[FW] || r_cnt == (FW+1)'(NUM_FRAMES)
                        || r_nres == 6'(MAX_RESULTS)) begin
                        if (!r_flush_any) begin
                            r_out   <= mk;
                            r_state <= S_OUT;
                        end else if (!r_out_valid || !i_out_stall) begin
                            r_out       <= pend_last;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_addr  <= w_idx;
                        r_state <= S_FLCHK;
                    end
                end
                S_FLCHK: begin
                    if (r_valid[r_addr] && r_dirty[r_addr] && key_eq) begin
                        // send the held beat before holding this one
                        if (!r_flush_any || !r_out_valid || !i_out_stall) begin
                            if (r_flush_any) begin
                                r_out       <= r_pend;
                                r_out_valid <= 1'b1;
                            end
                            r_flush_any <= 1'b1;
                            r_dirty[r_addr] <= 1'b0;
                            r_pend <= '{status: ST_OK, frame_index: 5'(r_addr),
                                        need_read: 1'b0, writeback_valid: 1'b1,
                                        writeback_file: r_cmd.file_id,
                                        writeback_page: tag_rdata[23:0],
                                        last: 1'b0};
                            r_nres <= r_nres + 1'b1;
                            r_walk <= r_next[r_addr];
                            r_cnt  <= r_cnt + 1'b1;
                            r_state <= S_FLRD;
                        end
                    end else begin
                        r_walk <= r_next[r_addr];
                        r_cnt  <= r_cnt + 1'b1;
                        r_state <= S_FLRD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    `PFBM_ASSERT(a_stall_busy, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> o_in_stall, "input taken while busy")
    `PFBM_ASSERT(a_cfg_idle, i_clk, i_rst_n,
        o_cfg_ready |-> (r_state == S_IDLE && !o_out_valid), "cfg ready while busy")
    `PFBM_ASSERT(a_onehot, i_clk, i_rst_n,
        $onehot(r_state), "state not one-hot")
    `PFBM_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_stall, o_out,
        "stalled result beat changed")
endmodule

### verif/page_frame_buffer_manager_unit_checker.sv
// Checker for the page frame buffer manager: watches the command, result and
// config channels, keeps its own model of the frame pool and compares beats.
// Depends on pfbm_pkg.
`timescale 1ns / 100ps
module page_frame_buffer_manager_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pfbm_pkg::t_in_beat  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pfbm_pkg::t_out_beat i_out,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [5:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import pfbm_pkg::*;

    localparam int NF  = NUM_FRAMES_DEF;
    localparam int NIL = -1;

    int          pool_size;
    logic [9:0]  tag_file [NF];
    logic [23:0] tag_page [NF];
    logic [7:0]  pins     [NF];
    bit          dirty    [NF];
    bit          valid    [NF];
    int          nxt      [NF];
    int          prv      [NF];
    int          free_head, mru, lru;

    t_out_beat   result_q [$];

    function automatic void pool_clear();
        for (int i = 0; i < NF; i++) begin
            tag_file[i] = '0;
            tag_page[i] = '0;
            pins[i]     = '0;
            dirty[i]    = 0;
            valid[i]    = 0;
            nxt[i]      = (i + 1 < pool_size) ? i + 1 : NIL;
            prv[i]      = (i > 0 && i < pool_size) ? i - 1 : NIL;
        end
        free_head = 0;
        mru       = NIL;
        lru       = NIL;
    endfunction

    function automatic void add_result(logic [1:0] st, int fr, bit rd, bit wv,
                                       logic [9:0] wf, logic [23:0] wp, bit lst);
        t_out_beat b;
        b.status          = st;
        b.frame_index     = fr[4:0];
        b.need_read       = rd;
        b.writeback_valid = wv;
        b.writeback_file  = wf;
        b.writeback_page  = wp;
        b.last            = lst;
        result_q.push_back(b);
    endfunction

    function automatic void push_mru(int s);
        prv[s] = NIL;
        nxt[s] = mru;
        if (mru != NIL) prv[mru] = s;
        else lru = s;
        mru = s;
    endfunction

    function automatic void unlink(int s);
        int p, n;
        p = prv[s];
        n = nxt[s];
        if (p != NIL) nxt[p] = n; else mru = n;
        if (n != NIL) prv[n] = p; else lru = p;
    endfunction

    // Free chain first, else oldest unpinned frame walking from the LRU end.
    function automatic int claim_frame(output bit wv, output logic [9:0] wf,
                                       output logic [23:0] wp);
        int s;
        wv = 0;
        wf = '0;
        wp = '0;
        if (free_head != NIL) begin
            s = free_head;
            free_head = nxt[s];
            if (free_head != NIL) prv[free_head] = NIL;
            push_mru(s);
            return s;
        end
        s = lru;
        for (int k = 0; k < NF && s != NIL; k++) begin
            if (pins[s] == 0) begin
                if (dirty[s]) begin
                    wv = 1;
                    wf = tag_file[s];
                    wp = tag_page[s];
                end
                unlink(s);
                push_mru(s);
                return s;
            end
            s = prv[s];
        end
        return NIL;
    endfunction

    function automatic void predict_command(t_in_beat b);
        int          s, n;
        bit          wv;
        logic [9:0]  wf;
        logic [23:0] wp;
        if (b.cmd > CMD_FLUSH) begin
            add_result(ST_OK, 0, 0, 0, '0, '0, 1);
            return;
        end
        if (b.cmd == CMD_FLUSH) begin
            n = 0;
            s = mru;
            for (int k = 0; k < NF && s != NIL && n < MAX_RESULTS; k++) begin
                if (valid[s] && tag_file[s] == b.file_id && dirty[s]) begin
                    dirty[s] = 0;
                    add_result(ST_OK, s, 0, 1, b.file_id, tag_page[s], 0);
                    n++;
                end
                s = nxt[s];
            end
            if (n == 0) add_result(ST_OK, 0, 0, 0, '0, '0, 1);
            else result_q[$].last = 1;
            return;
        end
        s = NIL;
        for (int i = NF - 1; i >= 0; i--)
            if (valid[i] && tag_file[i] == b.file_id && tag_page[i] == b.page_number)
                s = i;
        if (b.cmd == CMD_GET || b.cmd == CMD_ALLOC) begin
            if (s != NIL) begin
                if (b.cmd == CMD_ALLOC) begin
                    add_result(ST_PRESENT, s, 0, 0, '0, '0, 1);
                end else begin
                    if (pins[s] != 8'hFF) pins[s]++;
                    add_result(ST_OK, s, 0, 0, '0, '0, 1);
                end
                return;
            end
            s = claim_frame(wv, wf, wp);
            if (s == NIL) begin
                add_result(ST_NOFREE, 0, 0, 0, '0, '0, 1);
                return;
            end
            tag_file[s] = b.file_id;
            tag_page[s] = b.page_number;
            dirty[s]    = 0;
            valid[s]    = 1;
            pins[s]     = 8'd1;
            add_result(ST_OK, s, b.cmd == CMD_GET, wv, wf, wp, 1);
            return;
        end
        if (s == NIL) begin
            add_result(ST_ABSENT, 0, 0, 0, '0, '0, 1);
            return;
        end
        case (b.cmd)
            CMD_UNPIN: begin
                if (pins[s] != 0) pins[s]--;
                add_result(ST_OK, s, 0, 0, '0, '0, 1);
            end
            CMD_DIRTY: begin
                dirty[s] = 1;
                add_result(ST_OK, s, 0, 0, '0, '0, 1);
            end
            default: begin
                if (dirty[s]) begin
                    dirty[s] = 0;
                    add_result(ST_OK, s, 0, 1, b.file_id, b.page_number, 1);
                end else begin
                    add_result(ST_OK, s, 0, 0, '0, '0, 1);
                end
            end
        endcase
    endfunction

    task automatic compare_field(string name, longint unsigned exp_v,
                                 longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat e;
        if (!i_rst_n) begin
            pool_size    = NF;
            pool_clear();
            result_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                pool_size = (i_cfg_data < 1) ? 1 : (i_cfg_data > NF) ? NF : i_cfg_data;
                pool_clear();
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", i_out);
                    o_fail_count++;
                end else begin
                    e = result_q.pop_front();
                    compare_field("status", e.status, i_out.status);
                    compare_field("frame_index", e.frame_index, i_out.frame_index);
                    compare_field("need_read", e.need_read, i_out.need_read);
                    compare_field("writeback_valid", e.writeback_valid,
                                  i_out.writeback_valid);
                    compare_field("writeback_file", e.writeback_file,
                                  i_out.writeback_file);
                    compare_field("writeback_page", e.writeback_page,
                                  i_out.writeback_page);
                    compare_field("last", e.last, i_out.last);
                end
            end
            if (i_in_valid && !i_in_stall) predict_command(i_in);
        end
        o_pending = result_q.size();
    end
endmodule

### verif/page_frame_buffer_manager_unit_test.sv
// Testbench top for the page frame buffer manager: clock, reset, stimulus on
// the command and config channels, result-side stalls, watchdog and verdict.
// Depends on pfbm_pkg, page_frame_buffer_manager_unit and the checker module.
`timescale 1ns / 100ps
module page_frame_buffer_manager_unit_test;
    import pfbm_pkg::*;

    localparam int IDLE_LIMIT  = 8000;   // far above the longest quiet stretch
    localparam int DRAIN_WAIT  = 120;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_beat  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_beat o_out;
    logic      i_cfg_valid = 0;
    logic      o_cfg_ready;
    logic [5:0] i_cfg_data = '0;

    int fail_count, pending;
    bit tx_gaps, rx_gaps;        // per-phase switches for idling on each side
    int rx_hold;
    int idle_cycles;

    always #4 i_clk = ~i_clk;

    page_frame_buffer_manager_unit dut (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_stall, .i_in,
        .o_out_valid, .i_out_stall, .o_out,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    page_frame_buffer_manager_unit_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_stall(o_in_stall), .i_in,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out(o_out),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side: after each accepted beat, draw a stall length for the next.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold     <= rx_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (o_out_valid && !i_out_stall)
                rx_hold <= rx_gaps ? $urandom_range(0, 18) : 0;
        end
    end

    // Watchdog: any accepted beat on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One command beat. Valid is only dropped when a gap is drawn, so a
    // back-to-back beat never sees valid lowered and raised in one step.
    task automatic send_cmd(logic [2:0] cmd, logic [9:0] file, logic [23:0] page);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{cmd: cmd, file_id: file, page_number: page};
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Config writes only while the block is idle: drain, let the sequencer
    // settle, then write.
    task automatic write_pool_size(logic [5:0] size);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random beat over a small key space so hits, evictions and flushes
    // happen often; now and then a fully random key to toggle every bit.
    task automatic send_random_cmd();
        int          r;
        logic [2:0]  cmd;
        logic [9:0]  file;
        logic [23:0] page;
        r = $urandom_range(0, 99);
        cmd = (r < 30) ? CMD_GET : (r < 44) ? CMD_ALLOC : (r < 66) ? CMD_UNPIN :
              (r < 80) ? CMD_DIRTY : (r < 88) ? CMD_FORCE : (r < 96) ? CMD_FLUSH :
              3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) == 0) begin
            file = 10'($urandom);
            page = 24'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: file = 10'd0;
                1: file = 10'h3FF;
                default: file = 10'($urandom_range(1, 2));
            endcase
            case ($urandom_range(0, 5))
                0: page = 24'hFFFFFF;
                1: page = 24'h800000;
                default: page = 24'($urandom_range(0, 9));
            endcase
        end
        send_cmd(cmd, file, page);
    endtask

    initial begin
        logic [5:0] sizes [6] = '{6'd2, 6'd5, 6'd32, 6'd63, 6'd0, 6'd17};
        rx_hold = 0;
        tx_gaps = 1;
        rx_gaps = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset-sized pool, key extremes and every command.
        send_cmd(CMD_GET,   10'h3FF, 24'hFFFFFF);    // miss, read
        send_cmd(CMD_GET,   10'h3FF, 24'hFFFFFF);    // hit
        send_cmd(CMD_ALLOC, 10'h3FF, 24'hFFFFFF);    // already present
        send_cmd(CMD_ALLOC, 10'd0,   24'd0);
        send_cmd(CMD_UNPIN, 10'd0,   24'd0);
        send_cmd(CMD_UNPIN, 10'd0,   24'd0);         // unpin at zero pins
        send_cmd(CMD_DIRTY, 10'h3FF, 24'hFFFFFF);
        send_cmd(CMD_FORCE, 10'h3FF, 24'hFFFFFF);    // write-back
        send_cmd(CMD_FORCE, 10'h3FF, 24'hFFFFFF);    // clean page
        send_cmd(CMD_DIRTY, 10'd5,   24'd5);         // absent page
        send_cmd(CMD_UNPIN, 10'd5,   24'd5);
        send_cmd(CMD_FORCE, 10'd5,   24'd5);
        send_cmd(CMD_DIRTY, 10'h3FF, 24'hFFFFFF);
        send_cmd(CMD_DIRTY, 10'd0,   24'd0);
        send_cmd(CMD_FLUSH, 10'h3FF, 24'h123456);
        send_cmd(CMD_FLUSH, 10'h3FF, 24'd0);         // nothing dirty left
        send_cmd(3'd6,      10'h2AA, 24'h555555);
        send_cmd(3'd7,      10'h155, 24'hAAAAAA);

        // Single-frame pool: no free frame, dirty eviction, clean eviction.
        write_pool_size(6'd1);
        send_cmd(CMD_GET,   10'd1, 24'd1);
        send_cmd(CMD_GET,   10'd1, 24'd2);           // pinned: no free frame
        send_cmd(CMD_UNPIN, 10'd1, 24'd1);
        send_cmd(CMD_DIRTY, 10'd1, 24'd1);
        send_cmd(CMD_GET,   10'd1, 24'd2);           // evicts dirty page
        send_cmd(CMD_UNPIN, 10'd1, 24'd2);
        send_cmd(CMD_ALLOC, 10'd2, 24'd3);           // evicts clean page

        // Random phases over several pool sizes, clamped extremes included.
        foreach (sizes[p]) begin
            write_pool_size(sizes[p]);
            tx_gaps = (p % 3) != 1;
            rx_gaps = (p % 3) != 2;
            for (int i = 0; i < 39; i++) begin
                if (p == 2 && i == 20) drain_results();   // sender holds off
                send_random_cmd();
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/pfbm_pkg.sv
rtl/pfbm_ram.sv
rtl/page_frame_buffer_manager_unit.sv
verif/page_frame_buffer_manager_unit_checker.sv
verif/page_frame_buffer_manager_unit_test.sv
